// ----- hdl/tsf_pkg.sv -----
// ----------------------------------------------------------------------------
// tsf_pkg
// shared types, constants and helper functions of the tokenizer and stopword filter
// ----------------------------------------------------------------------------
package tsf_pkg;

    localparam int MAX_TERM_BYTES  = 64;
    localparam int STOP_ENTRIES    = 256;
    localparam int STOP_WORD_BYTES = 16;
    localparam int DEFAULT_WORDS   = 174;

    localparam int LEN_W     = 7;
    localparam int TIDX_W    = $clog2(MAX_TERM_BYTES);
    localparam int TBUF_AW   = TIDX_W + 1;
    localparam int WORD_W    = 8 * STOP_WORD_BYTES;
    localparam int SWLEN_W   = $clog2(STOP_WORD_BYTES + 2);
    localparam int ENTRY_W   = $clog2(STOP_ENTRIES);
    localparam int ENTRY_CW  = ENTRY_W + 1;

    typedef enum logic [1:0] {
        ACT_TEXT = 2'd0,
        ACT_EOT  = 2'd1,
        ACT_EDIT = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        JOB_TOKEN = 2'd0,
        JOB_ADD   = 2'd1,
        JOB_DEL   = 2'd2,
        JOB_EOT   = 2'd3
    } t_job_kind;

    typedef enum logic [2:0] {
        REG_SPLIT = 3'd0,
        REG_FOLD  = 3'd1,
        REG_DROP  = 3'd2,
        REG_MIN   = 3'd3,
        REG_MAX   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic             split;
        logic             fold;
        logic             drop;
        logic [LEN_W-1:0] min_len;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_job_kind         kind;
        logic              eot;
        logic              slot;
        logic [LEN_W-1:0]  len;
        logic [31:0]       start;
        logic [WORD_W-1:0] word;
    } t_job;

    typedef struct packed {
        logic               en;
        logic [TBUF_AW-1:0] addr;
        logic [7:0]         data;
    } t_buf_wr;

    typedef struct packed {
        logic init_done;
        logic rel;
        logic rel_slot;
    } t_back_stat;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [WORD_W-1:0] lower_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int k = 0; k < STOP_WORD_BYTES; k++) begin
            r[8*k +: 8] = lower_byte(w[8*k +: 8]);
        end
        return r;
    endfunction

    function automatic logic is_delim(input logic [7:0] c, input logic split);
        logic ws;
        logic pn;
        ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        pn = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
        return ws || (split && pn);
    endfunction

    // words are right-aligned, first byte highest, zero above
    function automatic logic [SWLEN_W-1:0] default_len(input logic [WORD_W-1:0] w);
        logic [SWLEN_W-1:0] n;
        n = '0;
        for (int k = 0; k < STOP_WORD_BYTES; k++) begin
            if (w[8*k +: 8] != 8'h00) n = SWLEN_W'(k + 1);
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] default_word(input logic [ENTRY_W-1:0] idx);
        logic [WORD_W-1:0] w;
        unique case (idx)
            8'd0: w = "a";          8'd1: w = "about";      8'd2: w = "above";
            8'd3: w = "after";      8'd4: w = "again";      8'd5: w = "against";
            8'd6: w = "all";        8'd7: w = "am";         8'd8: w = "an";
            8'd9: w = "and";        8'd10: w = "any";       8'd11: w = "are";
            8'd12: w = "aren't";    8'd13: w = "as";        8'd14: w = "at";
            8'd15: w = "be";        8'd16: w = "because";   8'd17: w = "been";
            8'd18: w = "before";    8'd19: w = "being";     8'd20: w = "below";
            8'd21: w = "between";   8'd22: w = "both";      8'd23: w = "but";
            8'd24: w = "by";        8'd25: w = "can't";     8'd26: w = "cannot";
            8'd27: w = "could";     8'd28: w = "couldn't";  8'd29: w = "did";
            8'd30: w = "didn't";    8'd31: w = "do";        8'd32: w = "does";
            8'd33: w = "doesn't";   8'd34: w = "doing";     8'd35: w = "don't";
            8'd36: w = "down";      8'd37: w = "during";    8'd38: w = "each";
            8'd39: w = "few";       8'd40: w = "for";       8'd41: w = "from";
            8'd42: w = "further";   8'd43: w = "had";       8'd44: w = "hadn't";
            8'd45: w = "has";       8'd46: w = "hasn't";    8'd47: w = "have";
            8'd48: w = "haven't";   8'd49: w = "having";    8'd50: w = "he";
            8'd51: w = "he'd";      8'd52: w = "he'll";     8'd53: w = "he's";
            8'd54: w = "her";       8'd55: w = "here";      8'd56: w = "here's";
            8'd57: w = "hers";      8'd58: w = "herself";   8'd59: w = "him";
            8'd60: w = "himself";   8'd61: w = "his";       8'd62: w = "how";
            8'd63: w = "how's";     8'd64: w = "i";         8'd65: w = "i'd";
            8'd66: w = "i'll";      8'd67: w = "i'm";       8'd68: w = "i've";
            8'd69: w = "if";        8'd70: w = "in";        8'd71: w = "into";
            8'd72: w = "is";        8'd73: w = "isn't";     8'd74: w = "it";
            8'd75: w = "it's";      8'd76: w = "its";       8'd77: w = "itself";
            8'd78: w = "let's";     8'd79: w = "me";        8'd80: w = "more";
            8'd81: w = "most";      8'd82: w = "mustn't";   8'd83: w = "my";
            8'd84: w = "myself";    8'd85: w = "no";        8'd86: w = "nor";
            8'd87: w = "not";       8'd88: w = "of";        8'd89: w = "off";
            8'd90: w = "on";        8'd91: w = "once";      8'd92: w = "only";
            8'd93: w = "or";        8'd94: w = "other";     8'd95: w = "ought";
            8'd96: w = "our";       8'd97: w = "ours";      8'd98: w = "ourselves";
            8'd99: w = "out";       8'd100: w = "over";     8'd101: w = "own";
            8'd102: w = "same";     8'd103: w = "shan't";   8'd104: w = "she";
            8'd105: w = "she'd";    8'd106: w = "she'll";   8'd107: w = "she's";
            8'd108: w = "should";   8'd109: w = "shouldn't"; 8'd110: w = "so";
            8'd111: w = "some";     8'd112: w = "such";     8'd113: w = "than";
            8'd114: w = "that";     8'd115: w = "that's";   8'd116: w = "the";
            8'd117: w = "their";    8'd118: w = "theirs";   8'd119: w = "them";
            8'd120: w = "themselves"; 8'd121: w = "then";   8'd122: w = "there";
            8'd123: w = "there's";  8'd124: w = "these";    8'd125: w = "they";
            8'd126: w = "they'd";   8'd127: w = "they'll";  8'd128: w = "they're";
            8'd129: w = "they've";  8'd130: w = "this";     8'd131: w = "those";
            8'd132: w = "through";  8'd133: w = "to";       8'd134: w = "too";
            8'd135: w = "under";    8'd136: w = "until";    8'd137: w = "up";
            8'd138: w = "very";     8'd139: w = "was";      8'd140: w = "wasn't";
            8'd141: w = "we";       8'd142: w = "we'd";     8'd143: w = "we'll";
            8'd144: w = "we're";    8'd145: w = "we've";    8'd146: w = "were";
            8'd147: w = "weren't";  8'd148: w = "what";     8'd149: w = "what's";
            8'd150: w = "when";     8'd151: w = "when's";   8'd152: w = "where";
            8'd153: w = "where's";  8'd154: w = "which";    8'd155: w = "while";
            8'd156: w = "who";      8'd157: w = "who's";    8'd158: w = "whom";
            8'd159: w = "why";      8'd160: w = "why's";    8'd161: w = "with";
            8'd162: w = "won't";    8'd163: w = "would";    8'd164: w = "wouldn't";
            8'd165: w = "you";      8'd166: w = "you'd";    8'd167: w = "you'll";
            8'd168: w = "you're";   8'd169: w = "you've";   8'd170: w = "your";
            8'd171: w = "yours";    8'd172: w = "yourself"; 8'd173: w = "yourselves";
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/tsf_in_if.sv -----
// ----------------------------------------------------------------------------
// tsf_in_if
// input word channel: text, end-of-text and stopword edit bytes
// ----------------------------------------------------------------------------
interface tsf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       edit_last;
    logic       edit_remove;

    modport source (output valid, action, data_byte, edit_last, edit_remove, input ready);
    modport sink   (input valid, action, data_byte, edit_last, edit_remove, output ready);
endinterface

// ----- hdl/tsf_out_if.sv -----
// ----------------------------------------------------------------------------
// tsf_out_if
// output word channel: one token byte per word
// ----------------------------------------------------------------------------
interface tsf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  term_byte;
    logic [31:0] token_position;
    logic [31:0] token_offset;
    logic [6:0]  token_length;
    logic        last_byte;

    modport source (output valid, term_byte, token_position, token_offset, token_length,
                    last_byte, input ready);
    modport sink   (input valid, term_byte, token_position, token_offset, token_length,
                    last_byte, output ready);
endinterface

// ----- hdl/text_tokenizer_stopword_filter_core.sv -----
// ----------------------------------------------------------------------------
// text_tokenizer_stopword_filter_core
// byte-stream tokenizer with length limits, case folding and stopword filter
// ----------------------------------------------------------------------------
// usage
//   i_item carries one word per byte: text byte, end of text, or stopword
//   edit byte (committed on edit_last, adding or removing the word)
//   o_term returns each passing token one byte per word, with its ordinal,
//   start offset and length; last_byte marks the final byte
//   the apb port holds split, fold, drop, min and max length; write only
//   while the block is idle
// timing
//   the front takes one input word per cycle; it waits while the job queue
//   is full or the token buffer slot it needs is still being replayed
//   a token job that needs a table lookup scans all 256 table rows through
//   one memory read port, then replays each byte through a read and a load
//   state; edits take the same scan; tokens with no lookup start replay at once
// reset
//   a load pass writes the 174 default stopword rows; no input word
//   is taken until it is over (config writes are taken as ever)
// stall
//   the output register holds a byte while o_term.ready is low and replay
//   waits; the front keeps accepting until the queue or buffer fills
// ----------------------------------------------------------------------------
module text_tokenizer_stopword_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsf_in_if.sink      i_item,
    tsf_out_if.source   o_term,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tsf_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   reg_idx;
    logic       cfg_wr;

    t_back_stat stat;
    t_buf_wr    buf_wr;
    t_job       push_job;
    t_job       head_job;
    logic       push_vld;
    logic       q_not_full;
    logic       head_vld;
    logic       pop;

    // apb: register i at byte address 4*i, pready tied high
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_SPLIT: prdata = {31'd0, r_cfg.split};
            REG_FOLD:  prdata = {31'd0, r_cfg.fold};
            REG_DROP:  prdata = {31'd0, r_cfg.drop};
            REG_MIN:   prdata = {25'd0, r_cfg.min_len};
            REG_MAX:   prdata = {25'd0, r_cfg.max_len};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split   <= 1'b1;
            r_cfg.fold    <= 1'b1;
            r_cfg.drop    <= 1'b1;
            r_cfg.min_len <= LEN_W'(1);
            r_cfg.max_len <= LEN_W'(MAX_TERM_BYTES);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SPLIT: r_cfg.split   <= pwdata[0];
                REG_FOLD:  r_cfg.fold    <= pwdata[0];
                REG_DROP:  r_cfg.drop    <= pwdata[0];
                REG_MIN:   r_cfg.min_len <= pwdata[LEN_W-1:0];
                REG_MAX:   r_cfg.max_len <= pwdata[LEN_W-1:0];
                default:   r_cfg         <= r_cfg;
            endcase
        end
    end

    // front: tokenizer and edit gatherer
    tsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_stat    (stat),
        .i_job_rdy (q_not_full),
        .o_job_vld (push_vld),
        .o_job     (push_job),
        .o_buf_wr  (buf_wr)
    );

    // jobs from front to back
    tsf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_vld),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_not_full (q_not_full),
        .o_vld      (head_vld),
        .o_job      (head_job)
    );

    // back: table search, table edits and byte replay
    tsf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_buf_wr  (buf_wr),
        .i_job_vld (head_vld),
        .i_job     (head_job),
        .o_job_pop (pop),
        .o_stat    (stat),
        .o_term    (o_term)
    );

endmodule

// ----- hdl/tsf_front.sv -----
// ----------------------------------------------------------------------------
// tsf_front
// accepts input words, splits tokens, gathers edits and queues jobs
// ----------------------------------------------------------------------------
module tsf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tsf_in_if.sink              i_item,
    input  tsf_pkg::t_cfg       i_cfg,
    input  tsf_pkg::t_back_stat i_stat,
    input  logic                i_job_rdy,
    output logic                o_job_vld,
    output tsf_pkg::t_job       o_job,
    output tsf_pkg::t_buf_wr    o_buf_wr
);
    import tsf_pkg::*;

    logic                r_in_token;
    logic [LEN_W-1:0]    r_count;
    logic [31:0]         r_start;
    logic [31:0]         r_offset;
    logic [WORD_W-1:0]   r_word;
    logic                r_wslot;
    logic [1:0]          r_busy;
    logic [WORD_W-1:0]   r_pend_word;
    logic [SWLEN_W-1:0]  r_pend_len;

    t_action             act;
    logic                acc;
    logic                delim;
    logic                tok_byte;
    logic                finish;
    logic                pass;
    logic [LEN_W-1:0]    hi;
    logic [LEN_W-1:0]    cnt0;
    logic [WORD_W-1:0]   word0;
    logic [WORD_W-1:0]   pend_base;
    logic [WORD_W-1:0]   pend_new;
    logic [SWLEN_W-1:0]  plen_new;
    logic                commit;

    assign act      = t_action'(i_item.action);
    assign i_item.ready = i_stat.init_done && i_job_rdy && !r_busy[r_wslot];
    assign acc      = i_item.valid && i_item.ready;
    assign delim    = is_delim(i_item.data_byte, i_cfg.split);
    assign tok_byte = acc && (act == ACT_TEXT) && !delim;
    assign finish   = acc && r_in_token && (((act == ACT_TEXT) && delim) || (act == ACT_EOT));
    assign hi       = (i_cfg.max_len > LEN_W'(MAX_TERM_BYTES)) ? LEN_W'(MAX_TERM_BYTES)
                                                               : i_cfg.max_len;
    assign pass     = finish && (r_count != '0) && (r_count >= i_cfg.min_len) &&
                      (r_count <= hi);
    assign cnt0     = r_in_token ? r_count : '0;
    assign word0    = r_in_token ? r_word : '0;

    assign pend_base = (r_pend_len == '0) ? '0 : r_pend_word;
    assign pend_new  = (r_pend_len < SWLEN_W'(STOP_WORD_BYTES)) ?
                       {pend_base[WORD_W-9:0], i_item.data_byte} : pend_base;
    assign plen_new  = r_pend_len + SWLEN_W'(r_pend_len <= SWLEN_W'(STOP_WORD_BYTES));
    assign commit    = acc && (act == ACT_EDIT) && i_item.edit_last;

    assign o_buf_wr.en   = tok_byte && (cnt0 < LEN_W'(MAX_TERM_BYTES));
    assign o_buf_wr.addr = {r_wslot, cnt0[TIDX_W-1:0]};
    assign o_buf_wr.data = i_item.data_byte;

    always_comb begin
        o_job_vld   = 1'b0;
        o_job.kind  = JOB_EOT;
        o_job.eot   = (act == ACT_EOT);
        o_job.slot  = r_wslot;
        o_job.len   = r_count;
        o_job.start = r_start;
        o_job.word  = r_word;
        if (pass) begin
            o_job_vld  = 1'b1;
            o_job.kind = JOB_TOKEN;
        end else if (acc && (act == ACT_EOT)) begin
            o_job_vld  = 1'b1;
            o_job.kind = JOB_EOT;
        end else if (commit && (plen_new <= SWLEN_W'(STOP_WORD_BYTES))) begin
            o_job_vld  = 1'b1;
            o_job.kind = i_item.edit_remove ? JOB_DEL : JOB_ADD;
            o_job.len  = LEN_W'(plen_new);
            o_job.word = pend_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_token <= 1'b0;
            r_count    <= '0;
            r_offset   <= '0;
            r_wslot    <= 1'b0;
            r_busy     <= '0;
            r_pend_len <= '0;
        end else begin
            // release of the replayed slot and claim of the filled one may coincide, but never name the same slot
            r_busy <= (r_busy & ~(2'(i_stat.rel) << i_stat.rel_slot)) |
                      (2'(pass) << r_wslot);
            if (tok_byte) begin
                r_in_token <= 1'b1;
                if (!r_in_token) r_start <= r_offset;
                r_count <= cnt0 + LEN_W'(cnt0 <= LEN_W'(MAX_TERM_BYTES));
                r_word  <= (cnt0 < LEN_W'(STOP_WORD_BYTES)) ?
                           {word0[WORD_W-9:0], i_item.data_byte} : word0;
            end
            // an end of text inside a token is a finish too
            if (finish) begin
                r_in_token <= 1'b0;
                r_count    <= '0;
            end
            if (pass) r_wslot <= ~r_wslot;
            if (acc && (act == ACT_TEXT)) r_offset <= r_offset + 32'd1;
            if (acc && (act == ACT_EOT)) r_offset <= '0;
            if (acc && (act == ACT_EDIT)) begin
                r_pend_word <= pend_new;
                r_pend_len  <= commit ? '0 : plen_new;
            end
        end
    end

endmodule

// ----- hdl/tsf_queue.sv -----
// ----------------------------------------------------------------------------
// tsf_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module tsf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_not_full,
    output logic          o_vld,
    output tsf_pkg::t_job o_job
);
    import tsf_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_not_full = (r_cnt != 2'd2);
    assign o_vld      = (r_cnt != 2'd0);
    assign o_job      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- hdl/tsf_back.sv -----
// ----------------------------------------------------------------------------
// tsf_back
// stopword table search and update, token byte replay to the output
// ----------------------------------------------------------------------------
module tsf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsf_pkg::t_cfg       i_cfg,
    input  tsf_pkg::t_buf_wr    i_buf_wr,
    input  logic                i_job_vld,
    input  tsf_pkg::t_job       i_job,
    output logic                o_job_pop,
    output tsf_pkg::t_back_stat o_stat,
    tsf_out_if.source           o_term
);
    import tsf_pkg::*;

    typedef struct packed {
        logic [SWLEN_W-1:0] len;
        logic [WORD_W-1:0]  word;
    } t_row;

    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_SCAN = 7'b0000100,
        ST_ACT  = 7'b0001000,
        ST_READ = 7'b0010000,
        ST_LOAD = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state               r_state;
    logic [7:0]           r_tok_mem [2*MAX_TERM_BYTES];
    logic [7:0]           r_tok_rd;
    t_row                 r_tab_mem [STOP_ENTRIES];
    t_row                 r_tab_rd;
    logic [STOP_ENTRIES-1:0] r_valid;
    logic [ENTRY_W-1:0]   r_init;
    logic [ENTRY_CW-1:0]  r_scan;
    logic                 r_cmp_vld;
    logic [ENTRY_W-1:0]   r_cmp_idx;
    logic                 r_hit;
    logic [ENTRY_W-1:0]   r_hit_idx;
    logic                 r_free_found;
    logic [ENTRY_W-1:0]   r_free_idx;
    logic [WORD_W-1:0]    r_jword;
    logic [TIDX_W-1:0]    r_k;
    logic [31:0]          r_pos;

    logic                 r_out_vld;
    logic [7:0]           r_out_byte;
    logic [31:0]          r_out_pos;
    logic [31:0]          r_out_off;
    logic [LEN_W-1:0]     r_out_len;
    logic                 r_out_last;

    logic                 tab_we;
    logic [ENTRY_W-1:0]   tab_waddr;
    t_row                 tab_wdata;
    logic [WORD_W-1:0]    rom_word;
    logic                 row_match;
    logic                 out_free;
    logic                 last_k;
    logic                 load_go;

    assign rom_word  = default_word(r_init);
    assign row_match = r_cmp_vld && r_valid[r_cmp_idx] &&
                       (r_tab_rd.len == i_job.len[SWLEN_W-1:0]) && (r_tab_rd.word == r_jword);
    assign out_free  = !r_out_vld || o_term.ready;
    assign last_k    = (LEN_W'(r_k) == i_job.len - LEN_W'(1));
    assign load_go   = (r_state == ST_LOAD) && out_free;

    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = r_init;
        tab_wdata = {default_len(rom_word), rom_word};
        if (r_state == ST_INIT) begin
            tab_we = 1'b1;
        end else if (r_state == ST_ACT && i_job.kind == JOB_ADD && !r_hit && r_free_found) begin
            tab_we    = 1'b1;
            tab_waddr = r_free_idx;
            tab_wdata = {i_job.len[SWLEN_W-1:0], r_jword};
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab_mem[tab_waddr] <= tab_wdata;
        r_tab_rd <= r_tab_mem[r_scan[ENTRY_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) r_tok_mem[i_buf_wr.addr] <= i_buf_wr.data;
        r_tok_rd <= r_tok_mem[{i_job.slot, r_k}];
    end

    assign o_job_pop        = (r_state == ST_DONE) ||
                              (r_state == ST_IDLE && i_job_vld && i_job.kind == JOB_EOT);
    assign o_stat.init_done = (r_state != ST_INIT);
    assign o_stat.rel       = (r_state == ST_DONE) && (i_job.kind == JOB_TOKEN);
    assign o_stat.rel_slot  = i_job.slot;

    assign o_term.valid          = r_out_vld;
    assign o_term.term_byte      = r_out_byte;
    assign o_term.token_position = r_out_pos;
    assign o_term.token_offset   = r_out_off;
    assign o_term.token_length   = r_out_len;
    assign o_term.last_byte      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_init    <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
            for (int e = 0; e < STOP_ENTRIES; e++) begin
                r_valid[e] <= (e < DEFAULT_WORDS);
            end
        end else begin
            // a new byte loads as the old one leaves
            if (load_go) r_out_vld <= 1'b1;
            else if (o_term.ready) r_out_vld <= 1'b0;
            unique case (r_state)
                ST_INIT: begin
                    r_init <= r_init + ENTRY_W'(1);
                    if (r_init == ENTRY_W'(DEFAULT_WORDS - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    r_scan       <= '0;
                    r_cmp_vld    <= 1'b0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                    r_k          <= '0;
                    r_jword      <= (i_cfg.fold && i_job.kind != JOB_DEL) ?
                                    lower_word(i_job.word) : i_job.word;
                    if (i_job_vld) begin
                        unique case (i_job.kind)
                            JOB_TOKEN: begin
                                if (i_cfg.drop && i_job.len <= LEN_W'(STOP_WORD_BYTES))
                                    r_state <= ST_SCAN;
                                else
                                    r_state <= ST_READ;
                            end
                            JOB_ADD, JOB_DEL: r_state <= ST_SCAN;
                            JOB_EOT: r_pos <= '0;
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (!r_scan[ENTRY_W]) r_scan <= r_scan + ENTRY_CW'(1);
                    r_cmp_vld <= !r_scan[ENTRY_W];
                    r_cmp_idx <= r_scan[ENTRY_W-1:0];
                    if (row_match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                    end
                    if (r_cmp_vld && !r_free_found && !r_valid[r_cmp_idx]) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_cmp_idx;
                    end
                    if (r_cmp_vld && r_cmp_idx == ENTRY_W'(STOP_ENTRIES - 1))
                        r_state <= ST_ACT;
                end
                ST_ACT: begin
                    unique case (i_job.kind)
                        JOB_TOKEN: r_state <= r_hit ? ST_DONE : ST_READ;
                        JOB_ADD: begin
                            if (!r_hit && r_free_found) r_valid[r_free_idx] <= 1'b1;
                            r_state <= ST_DONE;
                        end
                        JOB_DEL: begin
                            if (r_hit) r_valid[r_hit_idx] <= 1'b0;
                            r_state <= ST_DONE;
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_READ: r_state <= ST_LOAD;
                ST_LOAD: begin
                    if (out_free) begin
                        r_out_byte <= i_cfg.fold ? lower_byte(r_tok_rd) : r_tok_rd;
                        r_out_pos  <= r_pos;
                        r_out_off  <= i_job.start;
                        r_out_len  <= i_job.len;
                        r_out_last <= last_k;
                        if (last_k) begin
                            r_pos   <= r_pos + 32'd1;
                            r_state <= ST_DONE;
                        end else begin
                            r_k     <= r_k + TIDX_W'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_DONE: begin
                    if (i_job.kind == JOB_TOKEN && i_job.eot) r_pos <= '0;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/tsf_checker.sv -----
// ----------------------------------------------------------------------------
// tsf_checker
// port-level checks on the output channel and config port
// ----------------------------------------------------------------------------
module tsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_term_byte,
    input logic [6:0] i_token_length,
    input logic       i_last_byte,
    input logic       i_pready
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output word dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_term_byte) && $stable(i_last_byte))
        else $error("output word changed while stalled");

    a_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_token_length != 7'd0 && i_token_length <= 7'd64)
        else $error("token length out of range");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid && i_pready)
        else $error("output active after reset");

endmodule

bind text_tokenizer_stopword_filter_core tsf_checker u_tsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_term.valid),
    .i_ready        (o_term.ready),
    .i_term_byte    (o_term.term_byte),
    .i_token_length (o_term.token_length),
    .i_last_byte    (o_term.last_byte),
    .i_pready       (pready)
);
